### rtl/mbeq_pkg.sv
// Shared types, constants and helpers for the masked broadcast event queues.
// Used by the controller, the datapath and the top level. It has no dependencies.
package mbeq_pkg;

  // Sizing of the subscriber set and of each ring queue.
  localparam int unsigned Subscribers = 4;
  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned MaskRegs    = 4;
  localparam int unsigned NumMaskSubs = (Subscribers < MaskRegs) ? Subscribers : MaskRegs;
  localparam int unsigned PtrW        = $clog2(QueueDepth);

  // Field widths of the stream items.
  localparam int unsigned TypeW    = 32;
  localparam int unsigned PayloadW = 64;
  localparam int unsigned IdxW     = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned MaskOutW = 4;
  localparam int unsigned EntryW   = TypeW + PayloadW;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 104;

  // Configuration port widths.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [StatusW-1:0] {
    StOk      = 2'd0,
    StNoAuth  = 2'd1,
    StEmpty   = 2'd2
  } status_e;

  typedef enum logic {
    ReqPublish = 1'b0,
    ReqPop     = 1'b1
  } req_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_POP_RD = 1'b1
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic pop_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic pop_hit;
  } dp_stat_t;

  // Advance a ring pointer, wrapping after the last slot.
  function automatic logic [PtrW-1:0] ring_next(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(QueueDepth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

endpackage

### rtl/masked_broadcast_event_queues_unit.sv
// Top level of the masked broadcast event queues: stream ports and config port.
// Depends on mbeq_pkg, mbeq_ctrl and mbeq_datapath.
//
// Each of four subscribers owns a 32-bit type mask and a ring queue of 16 slots
// that holds up to 15 events. A publish request is copied into every queue whose
// mask shares a bit with the event type and is dropped for any full queue; a pop
// request returns the oldest event of one subscriber or reports an empty queue.
// Requests with authorized low change nothing and report status 1. Writing a
// mask register empties that subscriber's queue. A publish, a refused request and
// an empty pop load their result directly; a pop that finds an event first waits for
// the registered read of the queue RAM. A result waits in an output register, so the
// next request is taken in the cycle in which the previous result is collected.
// Configuration writes are always accepted and belong in idle periods only.
module masked_broadcast_event_queues_unit import mbeq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write channel
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // tdata: sub_index[1:0], event_type[33:2], payload[97:34], authorized[98], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // tuser: req_type[0]
  input  logic                s_axis_tuser,
  // Result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // tdata: out_type[31:0], out_payload[95:32], delivered_mask[99:96],
  //        dropped_mask[103:100]
  output logic [OutDataW-1:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [StatusW-1:0]  m_axis_tuser
);

  dp_cmd_t             cmd;
  dp_stat_t            stat;
  logic [TypeW-1:0]    out_type;
  logic [PayloadW-1:0] out_payload;
  logic [MaskOutW-1:0] dlv_mask;
  logic [MaskOutW-1:0] drp_mask;

  assign cfg_ready_o = 1'b1;

  // Controller.
  mbeq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath with unpacked request fields.
  mbeq_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_wr_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (s_axis_tuser),
    .sub_index_i      (s_axis_tdata[1:0]),
    .event_type_i     (s_axis_tdata[33:2]),
    .payload_i        (s_axis_tdata[97:34]),
    .authorized_i     (s_axis_tdata[98]),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .status_o         (m_axis_tuser),
    .out_type_o       (out_type),
    .out_payload_o    (out_payload),
    .delivered_mask_o (dlv_mask),
    .dropped_mask_o   (drp_mask)
  );

  // Pack the result fields.
  assign m_axis_tdata = {drp_mask, dlv_mask, out_payload, out_type};

endmodule

### rtl/mbeq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-subscriber event storage. It has no dependencies.
module mbeq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/mbeq_ctrl.sv
// Controller state machine: accepts requests and sequences the pop read.
// Depends on mbeq_pkg.
module mbeq_ctrl import mbeq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o
);

  ctrl_state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a pop that finds an event moves to S_POP_RD to wait for the RAM read.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o && stat_i.pop_hit) begin
          state_d = S_POP_RD;
        end
      end
      S_POP_RD: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs: requests are taken only when the result register will be free.
  always_comb begin
    in_ready_o     = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.pop_load = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        cmd_o.take = in_valid_i && stat_i.out_free;
      end
      S_POP_RD: cmd_o.pop_load = 1'b1;
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // No request is taken while a pop read is in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP_RD |-> !in_ready_o && !cmd_o.take)
    else $error("request taken during pop read");

endmodule

### rtl/mbeq_datapath.sv
// Datapath: subscriber masks, ring pointers, queue RAMs and the result register.
// Depends on mbeq_pkg and mbeq_ram.
module mbeq_datapath import mbeq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Configuration write
  input  logic                cfg_wr_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // Request fields
  input  logic                req_type_i,
  input  logic [IdxW-1:0]     sub_index_i,
  input  logic [TypeW-1:0]    event_type_i,
  input  logic [PayloadW-1:0] payload_i,
  input  logic                authorized_i,
  // Controller interface
  input  dp_cmd_t             cmd_i,
  output dp_stat_t            stat_o,
  // Result
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [StatusW-1:0]  status_o,
  output logic [TypeW-1:0]    out_type_o,
  output logic [PayloadW-1:0] out_payload_o,
  output logic [MaskOutW-1:0] delivered_mask_o,
  output logic [MaskOutW-1:0] dropped_mask_o
);

  logic                is_publish;
  logic [MaskOutW-1:0] match_v;
  logic [MaskOutW-1:0] full_v;
  logic [MaskOutW-1:0] empty_v;
  logic [MaskOutW-1:0] we_v;
  logic [EntryW-1:0]   rdata_v [MaskOutW];
  logic [IdxW-1:0]     pop_sel_q;
  logic                pop_hit;
  logic                load_now;
  logic                load_any;

  logic                out_valid_q, out_valid_d;
  logic [StatusW-1:0]  out_status_q, out_status_d;
  logic [TypeW-1:0]    out_type_q, out_type_d;
  logic [PayloadW-1:0] out_payload_q, out_payload_d;
  logic [MaskOutW-1:0] out_dlv_q, out_dlv_d;
  logic [MaskOutW-1:0] out_drp_q, out_drp_d;

  assign is_publish = authorized_i && (req_type_i == ReqPublish);
  assign pop_hit    = authorized_i && (req_type_i == ReqPop) && !empty_v[sub_index_i];

  // One lane per subscriber; lanes without a mask register stay empty.
  for (genvar i = 0; i < MaskOutW; i++) begin : g_lane
    if (i < NumMaskSubs) begin : g_sub
      logic [TypeW-1:0] mask_q, mask_d;
      logic [PtrW-1:0]  rp_q, rp_d, wp_q, wp_d;
      logic             cfg_hit;
      logic             re;

      assign cfg_hit    = cfg_wr_i && (cfg_index_i == CfgIdxW'(i));
      assign match_v[i] = |(mask_q & event_type_i);
      assign full_v[i]  = (ring_next(wp_q) == rp_q);
      assign empty_v[i] = (wp_q == rp_q);
      assign we_v[i]    = cmd_i.take && is_publish && match_v[i] && !full_v[i];
      assign re         = cmd_i.take && pop_hit && (sub_index_i == IdxW'(i));

      // Mask and pointer update; a mask write empties the queue.
      always_comb begin
        mask_d = mask_q;
        rp_d   = rp_q;
        wp_d   = wp_q;
        if (cfg_hit) begin
          mask_d = cfg_data_i;
          rp_d   = '0;
          wp_d   = '0;
        end else begin
          if (we_v[i]) begin
            wp_d = ring_next(wp_q);
          end
          if (re) begin
            rp_d = ring_next(rp_q);
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          mask_q <= '0;
          rp_q   <= '0;
          wp_q   <= '0;
        end else begin
          mask_q <= mask_d;
          rp_q   <= rp_d;
          wp_q   <= wp_d;
        end
      end

      mbeq_ram #(
        .Width (EntryW),
        .Depth (QueueDepth)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (we_v[i]),
        .waddr_i (wp_q),
        .wdata_i ({payload_i, event_type_i}),
        .re_i    (re),
        .raddr_i (rp_q),
        .rdata_o (rdata_v[i])
      );
    end else begin : g_none
      assign match_v[i] = 1'b0;
      assign full_v[i]  = 1'b0;
      assign empty_v[i] = 1'b1;
      assign we_v[i]    = 1'b0;
      assign rdata_v[i] = '0;
    end
  end

  // Remember which queue a pop reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      pop_sel_q <= sub_index_i;
    end
  end

  // Result selection: immediate for publish, refusal and empty pop.
  assign load_now = cmd_i.take && !pop_hit;
  assign load_any = load_now || cmd_i.pop_load;

  always_comb begin
    out_status_d  = StOk;
    out_type_d    = '0;
    out_payload_d = '0;
    out_dlv_d     = '0;
    out_drp_d     = '0;
    if (cmd_i.pop_load) begin
      out_type_d    = rdata_v[pop_sel_q][TypeW-1:0];
      out_payload_d = rdata_v[pop_sel_q][EntryW-1:TypeW];
    end else if (!authorized_i) begin
      out_status_d = StNoAuth;
    end else if (req_type_i == ReqPop) begin
      out_status_d = StEmpty;
    end else begin
      out_dlv_d = match_v & ~full_v;
      out_drp_d = match_v & full_v;
    end
  end

  assign out_valid_d = load_any || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_any) begin
      out_status_q  <= out_status_d;
      out_type_q    <= out_type_d;
      out_payload_q <= out_payload_d;
      out_dlv_q     <= out_dlv_d;
      out_drp_q     <= out_drp_d;
    end
  end

  assign stat_o.out_free  = !out_valid_q || out_ready_i;
  assign stat_o.pop_hit   = pop_hit;
  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign out_type_o       = out_type_q;
  assign out_payload_o    = out_payload_q;
  assign delivered_mask_o = out_dlv_q;
  assign dropped_mask_o   = out_drp_q;

  // A new result never overwrites one that has not been taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_any |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

  // A pop result is loaded only the cycle after a pop was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop_load |-> $past(cmd_i.take))
    else $error("pop load without a preceding request");

  // No subscriber both queues and drops the same event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_dlv_q & out_drp_q) == '0)
    else $error("event both delivered and dropped");

endmodule
